// ----- hdl/assert_macros.svh -----
// assertion macros shared by the buffer cache rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define BBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bbc_pkg.sv -----
// shared types and constants for the block buffer cache tag store
// no dependencies; imported by bbc_cell and block_buffer_cache_lru
package bbc_pkg;

   // default number of buffers and width of a buffer index (covers up to 256)
   localparam int BBC_NUM_BUFFERS = 32;
   localparam int IDX_W           = 8;
   localparam int CNT_W           = 8;
   localparam int TICK_W          = 32;
   localparam int DEV_W           = 8;
   localparam int BLK_W           = 32;
   localparam int SLOT_W          = 5;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NOFREE = 2'd1,
      STAT_UNDER  = 2'd2,
      STAT_OVER   = 2'd3
   } status_type;

   // request word
   typedef struct packed {
      logic [1:0]        opcode;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [SLOT_W-1:0] buffer_slot;
      logic [TICK_W-1:0] now_tick;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_out;
      logic              hit;
      logic              needs_fill;
   } rsp_word_type;

   // search word handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic [SLOT_W-1:0] slot;
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [CNT_W-1:0]  hit_cnt;
      logic              hit_dv;
      logic              free;
      logic [IDX_W-1:0]  free_idx;
      logic [TICK_W-1:0] free_tick;
      logic [CNT_W-1:0]  slot_cnt;
   } scan_word_type;

   // update broadcast to all cells
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic              retag;
      logic [DEV_W-1:0]  device;
      logic [BLK_W-1:0]  block_number;
      logic              cnt_we;
      logic [CNT_W-1:0]  cnt;
      logic              stamp;
      logic [TICK_W-1:0] tick;
      logic              set_dv;
   } commit_type;

endpackage

// ----- hdl/block_buffer_cache_lru.sv -----
// Block buffer cache tag store with least recently used replacement.
// Requests come in on req_valid/req_stall with a req_word (opcode, device,
// block_number, buffer_slot, now_tick); one response word per request leaves
// on rsp_valid/rsp_stall as rsp_word (status, slot_out, hit, needs_fill).
// A get looks up (device, block_number); on a miss it takes the unreferenced
// buffer with the oldest last-use tick, lowest index on ties. Release, pin
// and unpin adjust the count of the buffer named by buffer_slot.
// Each buffer is a cell in a chain; a search word walks the chain one cell
// per cycle, then the done state commits the update and loads the response.
// A new request is taken only after the last one has walked the whole chain
// and its response is loaded. req_stall is high while a request is in flight.
// A finished response may wait in the output register while the next request
// is accepted; if rsp_stall is still high when that request is done, the
// block holds its result and keeps req_stall high until the old word is taken.
// Reset (synchronous) empties the store: no tags, zero counts and ticks.
module block_buffer_cache_lru import bbc_pkg::*; #(
   parameter int NUM_BUFFERS = BBC_NUM_BUFFERS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

`include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   req_word_type     req_ff;
   scan_word_type    fin_ff;
   scan_word_type    head_w;
   scan_word_type    chain_w [NUM_BUFFERS+1];
   logic [NUM_BUFFERS-1:0] chain_valid;
   commit_type       commit;
   commit_type       cmt_c;
   logic             write_any;
   rsp_word_type     rsp_in;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;
   logic             accept;
   logic             out_free;
   logic             rsp_load;
   logic             in_range;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_DONE) && out_free;

   // search word injected at the head of the chain
   always_comb begin
      head_w              = '0;
      head_w.valid        = accept;
      head_w.device       = req_word.device;
      head_w.block_number = req_word.block_number;
      head_w.slot         = req_word.buffer_slot;
   end

   assign chain_w[0] = head_w;

   // chain of buffer cells
   for (genvar gi = 0; gi < NUM_BUFFERS; gi++) begin : g_cell
      bbc_cell #(
         .IDX(gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .word_in  (chain_w[gi]),
         .commit   (commit),
         .word_out (chain_w[gi+1])
      );
      assign chain_valid[gi] = chain_w[gi+1].valid;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_w[NUM_BUFFERS].valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request and finished search word holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (state_ff == ST_SCAN && chain_w[NUM_BUFFERS].valid) begin
         fin_ff <= chain_w[NUM_BUFFERS];
      end
   end

   assign in_range = 9'(req_ff.buffer_slot) < 9'(NUM_BUFFERS);

   // decide the update and the response from the search result
   always_comb begin
      cmt_c              = '0;
      cmt_c.device       = req_ff.device;
      cmt_c.block_number = req_ff.block_number;
      cmt_c.tick         = req_ff.now_tick;
      rsp_in             = '0;
      rsp_in.status      = STAT_OK;
      rsp_in.slot_out    = req_ff.buffer_slot;
      unique case (req_ff.opcode) inside
         OP_GET: begin
            if (fin_ff.hit) begin
               cmt_c.idx         = fin_ff.hit_idx;
               cmt_c.cnt_we      = 1'b1;
               cmt_c.set_dv      = 1'b1;
               rsp_in.slot_out   = fin_ff.hit_idx[SLOT_W-1:0];
               rsp_in.hit        = 1'b1;
               rsp_in.needs_fill = !fin_ff.hit_dv;
               if (fin_ff.hit_cnt == COUNT_MAX) begin
                  cmt_c.cnt     = fin_ff.hit_cnt;
                  rsp_in.status = STAT_OVER;
               end else begin
                  cmt_c.cnt = fin_ff.hit_cnt + CNT_W'(1);
               end
            end else if (fin_ff.free) begin
               cmt_c.idx         = fin_ff.free_idx;
               cmt_c.retag       = 1'b1;
               cmt_c.cnt_we      = 1'b1;
               cmt_c.cnt         = CNT_W'(1);
               cmt_c.set_dv      = 1'b1;
               rsp_in.slot_out   = fin_ff.free_idx[SLOT_W-1:0];
               rsp_in.needs_fill = 1'b1;
            end else begin
               rsp_in.status   = STAT_NOFREE;
               rsp_in.slot_out = '0;
            end
         end
         OP_PIN: begin
            if (in_range) begin
               cmt_c.idx    = IDX_W'(req_ff.buffer_slot);
               cmt_c.cnt_we = 1'b1;
               if (fin_ff.slot_cnt == COUNT_MAX) begin
                  cmt_c.cnt     = fin_ff.slot_cnt;
                  rsp_in.status = STAT_OVER;
               end else begin
                  cmt_c.cnt = fin_ff.slot_cnt + CNT_W'(1);
               end
            end
         end
         OP_RELEASE, OP_UNPIN: begin
            if (in_range) begin
               cmt_c.idx = IDX_W'(req_ff.buffer_slot);
               if (fin_ff.slot_cnt == '0) begin
                  rsp_in.status = STAT_UNDER;
               end else begin
                  cmt_c.cnt_we = 1'b1;
                  cmt_c.cnt    = fin_ff.slot_cnt - CNT_W'(1);
                  cmt_c.stamp  = (req_ff.opcode == OP_RELEASE)
                                 && (fin_ff.slot_cnt == CNT_W'(1));
               end
            end
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase
   end

   assign write_any = cmt_c.retag || cmt_c.cnt_we || cmt_c.stamp || cmt_c.set_dv;

   always_comb begin
      commit    = cmt_c;
      commit.en = rsp_load && write_any;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // at most one search word walks the chain
   `BBC_ASSERT(a_one_word, clock, reset, $onehot0(chain_valid), "more than one search word in chain")
   // the end of the chain is reached only while scanning
   `BBC_ASSERT(a_end_in_scan, clock, reset, chain_w[NUM_BUFFERS].valid |-> state_ff == ST_SCAN, "search word ended outside scan")
   // buffers change only when a response is loaded
   `BBC_ASSERT(a_commit_load, clock, reset, commit.en |-> rsp_load, "buffer update without response")
   // a loaded response is presented in the next cycle
   `BBC_ASSERT(a_load_valid, clock, reset, rsp_load |=> rsp_valid, "loaded response not presented")

endmodule

// ----- hdl/bbc_cell.sv -----
// one buffer of the tag store: holds its tag, count, tick and valid bit
// uses bbc_pkg; chained by block_buffer_cache_lru
module bbc_cell import bbc_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  scan_word_type word_in,
   input  commit_type    commit,
   output scan_word_type word_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic              tag_used_ff;
   logic [DEV_W-1:0]  device_tag_ff;
   logic [BLK_W-1:0]  block_tag_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [TICK_W-1:0] tick_ff;
   logic              dv_ff;
   scan_word_type     word_in_c;
   scan_word_type     word_ff;
   logic              match;
   logic              better;
   logic              mine;

   // tag compare and oldest free buffer compare for the passing word
   assign match  = tag_used_ff && (device_tag_ff == word_in.device)
                   && (block_tag_ff == word_in.block_number);
   assign better = (count_ff == '0) && (!word_in.free || (tick_ff < word_in.free_tick));
   assign mine   = commit.en && (commit.idx == MY_IDX);

   // fold this buffer into the search word
   always_comb begin
      word_in_c = word_in;
      if (match && !word_in.hit) begin
         word_in_c.hit     = 1'b1;
         word_in_c.hit_idx = MY_IDX;
         word_in_c.hit_cnt = count_ff;
         word_in_c.hit_dv  = dv_ff;
      end
      if (better) begin
         word_in_c.free      = 1'b1;
         word_in_c.free_idx  = MY_IDX;
         word_in_c.free_tick = tick_ff;
      end
      if (IDX_W'(word_in.slot) == MY_IDX) begin
         word_in_c.slot_cnt = count_ff;
      end
   end

   // hand the word to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in_c;
      end
   end

   assign word_out = word_ff;

   // buffer control state
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_used_ff <= 1'b0;
         count_ff    <= '0;
         tick_ff     <= '0;
         dv_ff       <= 1'b0;
      end else if (mine) begin
         if (commit.retag) begin
            tag_used_ff <= 1'b1;
         end
         if (commit.cnt_we) begin
            count_ff <= commit.cnt;
         end
         if (commit.stamp) begin
            tick_ff <= commit.tick;
         end
         if (commit.set_dv) begin
            dv_ff <= 1'b1;
         end
      end
   end

   // tag payload, meaningful only while tag_used is set
   always_ff @(posedge clock) begin
      if (mine && commit.retag) begin
         device_tag_ff <= commit.device;
         block_tag_ff  <= commit.block_number;
      end
   end

endmodule
